// ----- rtl/core/hex_literal_bit_reverser_unit_assert.svh -----
// Assertion macros for the hex literal bit reverser unit.
// Used by the top level; no dependencies.
`ifndef HEX_LITERAL_BIT_REVERSER_UNIT_ASSERT_SVH
`define HEX_LITERAL_BIT_REVERSER_UNIT_ASSERT_SVH

// Implication checked in the same cycle.
`define HLBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define HLBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/hlbr_pkg.sv -----
// Shared types, constants and helper functions of the hex literal bit reverser.
// No dependencies.
package hlbr_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_LX    = 8'h78;
    localparam logic [3:0] NIB_MASK   = 4'hF;
    localparam logic [3:0] LETTER_OFS = 4'd9;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ZERO   = 2'd1,
        PH_FIRST  = 2'd2,
        PH_SECOND = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  item0;
        t_out_item  item1;
    } t_scan_res;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.nib = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            h.ok  = 1'b1;
            h.nib = c[3:0];
        end else if ((c >= CHAR_UA && c <= CHAR_UF) || (c >= CHAR_LA && c <= CHAR_LF)) begin
            h.ok  = 1'b1;
            h.nib = (c[3:0] + LETTER_OFS) & NIB_MASK;
        end
        return h;
    endfunction

    function automatic logic [7:0] reverse_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/hlbr_in_if.sv -----
// Request channel carrying one input character.
// No dependencies.
interface hlbr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

// ----- rtl/core/hlbr_out_if.sv -----
// Request channel carrying one output character and its last-of-run flag.
// No dependencies.
interface hlbr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ----- rtl/core/hlbr_scan.sv -----
// Prefix scanner: phase state plus decode of 0, 1 or 2 results per character.
// Depends on hlbr_pkg.
module hlbr_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_char,
    output hlbr_pkg::t_scan_res o_res
);
    import hlbr_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_high, n_high;
    logic [7:0] r_held, n_held;
    t_hex       w_hex;
    logic [7:0] w_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_high  <= 4'd0;
            r_held  <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_held  <= n_held;
        end
    end

    always_comb begin
        w_hex   = hex_value(i_char);
        w_rev   = reverse_byte({r_high, w_hex.nib});
        n_phase = r_phase;
        n_high  = r_high;
        n_held  = r_held;
        o_res.count             = 2'd1;
        o_res.item0.out_char    = i_char;
        o_res.item0.last_of_run = 1'b1;
        o_res.item1.out_char    = i_char;
        o_res.item1.last_of_run = 1'b1;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_char == CHAR_ZERO) begin
                    n_phase = PH_ZERO;
                end
            end
            PH_ZERO: begin
                n_phase = (i_char == CHAR_LX) ? PH_FIRST : PH_IDLE;
            end
            PH_FIRST: begin
                if (w_hex.ok) begin
                    n_high      = w_hex.nib;
                    n_held      = i_char;
                    n_phase     = PH_SECOND;
                    o_res.count = 2'd0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_SECOND: begin
                n_phase                 = PH_IDLE;
                o_res.count             = 2'd2;
                o_res.item0.last_of_run = 1'b0;
                if (w_hex.ok) begin
                    o_res.item0.out_char = HEX_DIGITS[w_rev[7:4]];
                    o_res.item1.out_char = HEX_DIGITS[w_rev[3:0]];
                end else begin
                    o_res.item0.out_char = r_held;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/core/hlbr_fifo.sv -----
// Result queue: takes up to two items per cycle, releases one per cycle.
// Depends on hlbr_pkg.
module hlbr_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  hlbr_pkg::t_scan_res        i_res,
    input  logic                       i_pop,
    output logic                       o_room,
    output logic                       o_valid,
    output hlbr_pkg::t_out_item        o_item,
    output logic [hlbr_pkg::FIFO_CW-1:0] o_count
);
    import hlbr_pkg::*;

    t_out_item            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, n_wr;
    logic [FIFO_AW-1:0]   r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic [FIFO_CW-1:0]   w_push_n;
    logic [FIFO_AW-1:0]   w_wr1;

    always_comb begin
        w_push_n = i_push ? FIFO_CW'(i_res.count) : '0;
        w_wr1    = r_wr + FIFO_AW'(1);
        n_wr     = r_wr + FIFO_AW'(w_push_n);
        n_rd     = i_pop ? r_rd + FIFO_AW'(1) : r_rd;
        n_count  = r_count + w_push_n - (i_pop ? FIFO_CW'(1) : FIFO_CW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_n != '0) begin
            r_mem[r_wr] <= i_res.item0;
        end
        if (w_push_n == FIFO_CW'(2)) begin
            r_mem[w_wr1] <= i_res.item1;
        end
    end

    assign o_room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign o_count = r_count;
endmodule

// ----- rtl/core/hex_literal_bit_reverser_unit.sv -----
// Hex literal bit reverser: top level joining the scanner and the result queue.
// Depends on hlbr_pkg, hlbr_in_if, hlbr_out_if, hlbr_scan, hlbr_fifo and the assert header.
//
// Usage:
//   i_in_ch  carries one ASCII character per request (valid/ready).
//   o_out_ch carries output characters; last_of_run marks the final character
//   caused by one input character. A held first digit of a "0x" literal gives
//   no output; the second digit gives two (the bit-reversed byte in uppercase hex).
//   An output character is offered from the registered result queue once the
//   results ahead of it are taken. Throughput: one input per cycle while the
//   sink keeps up; the output side moves one character per cycle, so inputs that
//   cause two characters are taken more slowly. The single output channel sets this limit.
//   Input ready stays high while the queue has room for two more characters,
//   so inputs are taken while earlier results still wait at the output.
//   Receiver stall: results stay queued and input ready drops once the queue
//   cannot take two more characters.
//   Reset: synchronous, active low; scanner returns to idle, queue empties.
`include "hex_literal_bit_reverser_unit_assert.svh"
module hex_literal_bit_reverser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hlbr_in_if.sink     i_in_ch,
    hlbr_out_if.source  o_out_ch
);
    import hlbr_pkg::*;

    logic                w_accept;
    logic                w_pop;
    t_scan_res           w_res;
    t_out_item           w_item;
    logic                w_room;
    logic                w_valid;
    logic [FIFO_CW-1:0]  w_count;

    assign w_accept = i_in_ch.valid && i_in_ch.ready;
    assign w_pop    = o_out_ch.valid && o_out_ch.ready;

    hlbr_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_accept),
        .i_char  (i_in_ch.in_char),
        .o_res   (w_res)
    );

    hlbr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_res   (w_res),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (w_valid),
        .o_item  (w_item),
        .o_count (w_count)
    );

    assign i_in_ch.ready        = w_room;
    assign o_out_ch.valid       = w_valid;
    assign o_out_ch.out_char    = w_item.out_char;
    assign o_out_ch.last_of_run = w_item.last_of_run;

    `HLBR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        w_count <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
    `HLBR_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, w_accept && !w_pop,
        w_count == FIFO_CW'($past(w_count) + FIFO_CW'($past(w_res.count))),
        "queue count does not match pushed results")
    `HLBR_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, w_pop && !w_accept,
        w_count == FIFO_CW'($past(w_count) - FIFO_CW'(1)),
        "queue count does not drop on pop")
    `HLBR_ASSERT_NOW(a_pair_flags, i_clk, i_rst_n, w_accept && w_res.count == 2'd2,
        !w_res.item0.last_of_run && w_res.item1.last_of_run,
        "two-result input has wrong last flags")
endmodule
